### src/ptac_pkg.sv
// Package: types, codes and reset values for the pre-trigger anomaly capture block
`default_nettype none

package ptac_pkg;

    localparam int DefHistoryDepth = 64;
    localparam int DefCaptureDepth = 128;

    localparam int SampleW = 24;
    localparam int StampW  = 32;
    localparam int CountW  = 16;
    localparam int CfgW    = 24;

    localparam logic signed [SampleW-1:0] VoltageLimitReset = 24'sd5000;
    localparam logic signed [SampleW-1:0] CurrentLimitReset = 24'sd1000;
    localparam logic [CountW-1:0]         PostCountReset    = 16'd100;
    localparam logic [CountW-1:0]         HoldoffReset      = 16'd1000;

    typedef enum logic [1:0] {
        CMD_SAMPLE    = 2'd0,
        CMD_READ      = 2'd1,
        CMD_CLEAR_HIS = 2'd2,
        CMD_CLEAR_CAP = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_VOLTAGE_LIMIT = 2'd0,
        REG_CURRENT_LIMIT = 2'd1,
        REG_POST_COUNT    = 2'd2,
        REG_HOLDOFF       = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_COPY_RD,
        S_COPY_WR,
        S_PUSH
    } state_t;

    typedef struct packed {
        logic signed [SampleW-1:0] volts;
        logic signed [SampleW-1:0] amps;
        logic [StampW-1:0]         stamp;
        logic                      flag;
    } entry_t;

endpackage

`default_nettype wire

### src/pretrigger_anomaly_capture.sv
// Top level: pre-trigger / post-trigger anomaly capture with history ring and capture store
//
// channel   direction  handshake          payload
// in        in         in_valid/in_stall  command, volts_in, amps_in, time_in, read_index
// out       out        out_valid/out_stall over_limit .. entry_valid
// cfg       in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// An ordinary sample or command is transferred in, then evaluated once the output is free.
// A trigger runs COPY_RD then COPY_WR per history entry copied, then PUSH; each copy goes
// through the single read port of the history memory and then the capture write port.
// Reset clears state, pointers, fill counts and out_valid and loads the config defaults;
// memories need no clearing pass. The next input is taken while a result waits on a stalled output.
`default_nettype none

module pretrigger_anomaly_capture
#(
    parameter int HISTORY_DEPTH = ptac_pkg::DefHistoryDepth,
    parameter int CAPTURE_DEPTH = ptac_pkg::DefCaptureDepth
)
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,

    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic [1:0]                             command,
    input  wire logic signed [ptac_pkg::SampleW-1:0]    volts_in,
    input  wire logic signed [ptac_pkg::SampleW-1:0]    amps_in,
    input  wire logic [ptac_pkg::StampW-1:0]            time_in,
    input  wire logic [$clog2(CAPTURE_DEPTH)-1:0]       read_index,

    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic                                        over_limit,
    output logic                                        trigger_taken,
    output logic [$clog2(CAPTURE_DEPTH+1)-1:0]          capture_count,
    output logic [$clog2(HISTORY_DEPTH+1)-1:0]          history_count,
    output logic signed [ptac_pkg::SampleW-1:0]         entry_volts,
    output logic signed [ptac_pkg::SampleW-1:0]         entry_amps,
    output logic [ptac_pkg::StampW-1:0]                 entry_time,
    output logic                                        entry_flag,
    output logic                                        entry_valid,

    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [1:0]                             cfg_index,
    input  wire logic [ptac_pkg::CfgW-1:0]              cfg_data
);

    import ptac_pkg::*;

    localparam int HAW = $clog2(HISTORY_DEPTH);
    localparam int HCW = $clog2(HISTORY_DEPTH + 1);
    localparam int CAW = $clog2(CAPTURE_DEPTH);
    localparam int CCW = $clog2(CAPTURE_DEPTH + 1);
    localparam logic [HCW-1:0] HDepth = HCW'(HISTORY_DEPTH);
    localparam logic [HAW-1:0] HLast  = HAW'(HISTORY_DEPTH - 1);
    localparam logic [CCW-1:0] CDepth = CCW'(CAPTURE_DEPTH);

    // memories
    entry_t hist_mem [HISTORY_DEPTH];
    entry_t cap_mem  [CAPTURE_DEPTH];

    logic           hist_we;
    logic [HAW-1:0] hist_waddr;
    entry_t         hist_wdata;
    logic           hist_re;
    logic [HAW-1:0] hist_raddr;
    entry_t         hist_rdata_reg;

    logic           cap_we;
    logic [CAW-1:0] cap_waddr;
    entry_t         cap_wdata;
    logic           cap_re;
    entry_t         cap_rdata_reg;

    // control and state
    state_t state_reg, state_next;

    logic signed [SampleW-1:0] vlim_reg, vlim_next;
    logic signed [SampleW-1:0] ilim_reg, ilim_next;
    logic [CountW-1:0]         post_cnt_reg, post_cnt_next;
    logic [CountW-1:0]         holdoff_reg, holdoff_next;

    logic [HAW-1:0] hwp_reg, hwp_next;
    logic [HCW-1:0] hfill_reg, hfill_next;
    logic [CCW-1:0] cfill_reg, cfill_next;
    logic [CountW-1:0] post_left_reg, post_left_next;
    logic [StampW-1:0] last_trig_reg, last_trig_next;
    logic [HAW-1:0] cidx_reg, cidx_next;
    logic [HCW-1:0] ccnt_reg, ccnt_next;

    // held input transfer
    cmd_t                      cmd_reg;
    logic signed [SampleW-1:0] volts_reg;
    logic signed [SampleW-1:0] amps_reg;
    logic [StampW-1:0]         time_reg;
    logic [CAW-1:0]            ridx_reg;

    // output register
    logic                      out_valid_reg, out_valid_next;
    logic                      over_reg, over_next;
    logic                      trig_reg, trig_next;
    logic [CCW-1:0]            ccount_reg, ccount_next;
    logic [HCW-1:0]            hcount_reg, hcount_next;
    entry_t                    entry_reg, entry_next;
    logic                      evalid_reg, evalid_next;

    logic           in_xfer;
    logic           out_free;
    logic           over;
    logic           trig;
    logic [HCW-1:0] wp_ext;
    logic [HCW-1:0] start_ext;
    logic           cap_room;
    logic [CCW-1:0] cfill_push;
    logic [CCW-1:0] space;
    logic           ridx_ok;
    entry_t         sample_entry;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;
    assign cap_re    = in_xfer;

    assign over = (volts_reg > vlim_reg) || (amps_reg > ilim_reg);
    assign trig = over && ((time_reg - last_trig_reg) >= StampW'(holdoff_reg));

    assign wp_ext    = HCW'(hwp_reg);
    assign start_ext = (wp_ext >= hfill_reg) ? (wp_ext - hfill_reg)
                                             : (wp_ext + HDepth - hfill_reg);
    assign cap_room   = (cfill_reg < CDepth);
    assign cfill_push = cap_room ? (cfill_reg + CCW'(1)) : cfill_reg;
    assign space      = CDepth - cfill_push;
    assign ridx_ok    = (CCW'(ridx_reg) < cfill_reg) && (CCW'(ridx_reg) < CDepth);

    assign sample_entry = '{volts: volts_reg, amps: amps_reg, stamp: time_reg, flag: 1'b1};

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        if (hist_re)
        begin
            hist_rdata_reg <= hist_mem[hist_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cap_we)
        begin
            cap_mem[cap_waddr] <= cap_wdata;
        end
        if (cap_re)
        begin
            cap_rdata_reg <= cap_mem[read_index];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cmd_reg   <= cmd_t'(command);
            volts_reg <= volts_in;
            amps_reg  <= amps_in;
            time_reg  <= time_in;
            ridx_reg  <= read_index;
        end
        over_reg   <= over_next;
        trig_reg   <= trig_next;
        ccount_reg <= ccount_next;
        hcount_reg <= hcount_next;
        entry_reg  <= entry_next;
        evalid_reg <= evalid_next;
        cidx_reg   <= cidx_next;
        ccnt_reg   <= ccnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vlim_reg      <= VoltageLimitReset;
            ilim_reg      <= CurrentLimitReset;
            post_cnt_reg  <= PostCountReset;
            holdoff_reg   <= HoldoffReset;
            hwp_reg       <= '0;
            hfill_reg     <= '0;
            cfill_reg     <= '0;
            post_left_reg <= '0;
            last_trig_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vlim_reg      <= vlim_next;
            ilim_reg      <= ilim_next;
            post_cnt_reg  <= post_cnt_next;
            holdoff_reg   <= holdoff_next;
            hwp_reg       <= hwp_next;
            hfill_reg     <= hfill_next;
            cfill_reg     <= cfill_next;
            post_left_reg <= post_left_next;
            last_trig_reg <= last_trig_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // configuration writes
    always_comb
    begin
        vlim_next     = vlim_reg;
        ilim_next     = ilim_reg;
        post_cnt_next = post_cnt_reg;
        holdoff_next  = holdoff_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_VOLTAGE_LIMIT: vlim_next     = cfg_data;
                REG_CURRENT_LIMIT: ilim_next     = cfg_data;
                REG_POST_COUNT:    post_cnt_next = cfg_data[CountW-1:0];
                REG_HOLDOFF:       holdoff_next  = cfg_data[CountW-1:0];
                default:           vlim_next     = vlim_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        hwp_next       = hwp_reg;
        hfill_next     = hfill_reg;
        cfill_next     = cfill_reg;
        post_left_next = post_left_reg;
        last_trig_next = last_trig_reg;
        cidx_next      = cidx_reg;
        ccnt_next      = ccnt_reg;

        hist_we    = 1'b0;
        hist_waddr = hwp_reg;
        hist_wdata = '{volts: volts_reg, amps: amps_reg, stamp: time_reg, flag: over};
        hist_re    = 1'b0;
        hist_raddr = cidx_reg;
        cap_we     = 1'b0;
        cap_waddr  = cfill_reg[CAW-1:0];
        cap_wdata  = sample_entry;

        out_valid_next = out_valid_reg && out_stall;
        over_next      = over_reg;
        trig_next      = trig_reg;
        ccount_next    = ccount_reg;
        hcount_next    = hcount_reg;
        entry_next     = entry_reg;
        evalid_next    = evalid_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_EVAL;
                end
            end

            S_EVAL:
            begin
                if (cmd_reg == CMD_SAMPLE && trig)
                begin
                    last_trig_next = time_reg;
                    cidx_next      = start_ext[HAW-1:0];
                    ccnt_next      = '0;
                    state_next     = S_COPY_RD;
                end
                else if (out_free)
                begin
                    over_next   = 1'b0;
                    trig_next   = 1'b0;
                    entry_next  = '0;
                    evalid_next = 1'b0;
                    unique case (cmd_reg)
                        CMD_SAMPLE:
                        begin
                            over_next = over;
                            if (post_left_reg != '0 && cap_room)
                            begin
                                cap_we         = 1'b1;
                                cfill_next     = cfill_reg + CCW'(1);
                                post_left_next = post_left_reg - CountW'(1);
                            end
                            hist_we    = 1'b1;
                            hwp_next   = (hwp_reg == HLast) ? '0 : hwp_reg + HAW'(1);
                            hfill_next = (hfill_reg < HDepth) ? hfill_reg + HCW'(1)
                                                              : hfill_reg;
                        end
                        CMD_READ:
                        begin
                            if (ridx_ok)
                            begin
                                entry_next  = cap_rdata_reg;
                                evalid_next = 1'b1;
                            end
                        end
                        CMD_CLEAR_HIS:
                        begin
                            hwp_next   = '0;
                            hfill_next = '0;
                        end
                        CMD_CLEAR_CAP:
                        begin
                            cfill_next = '0;
                        end
                        default:
                        begin
                            cfill_next = cfill_reg;
                        end
                    endcase
                    out_valid_next = 1'b1;
                    ccount_next    = cfill_next;
                    hcount_next    = hfill_next;
                    state_next     = S_IDLE;
                end
            end

            S_COPY_RD:
            begin
                if (ccnt_reg < hfill_reg && cap_room)
                begin
                    hist_re    = 1'b1;
                    state_next = S_COPY_WR;
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end

            S_COPY_WR:
            begin
                cap_we     = 1'b1;
                cap_wdata  = hist_rdata_reg;
                cfill_next = cfill_reg + CCW'(1);
                cidx_next  = (cidx_reg == HLast) ? '0 : cidx_reg + HAW'(1);
                ccnt_next  = ccnt_reg + HCW'(1);
                state_next = S_COPY_RD;
            end

            S_PUSH:
            begin
                if (out_free)
                begin
                    cap_we         = cap_room;
                    cfill_next     = cfill_push;
                    post_left_next = (post_cnt_reg < CountW'(space)) ? post_cnt_reg
                                                                     : CountW'(space);
                    hist_we        = 1'b1;
                    hwp_next       = (hwp_reg == HLast) ? '0 : hwp_reg + HAW'(1);
                    hfill_next     = (hfill_reg < HDepth) ? hfill_reg + HCW'(1) : hfill_reg;
                    out_valid_next = 1'b1;
                    over_next      = 1'b1;
                    trig_next      = 1'b1;
                    ccount_next    = cfill_next;
                    hcount_next    = hfill_next;
                    entry_next     = '0;
                    evalid_next    = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign over_limit    = over_reg;
    assign trigger_taken = trig_reg;
    assign capture_count = ccount_reg;
    assign history_count = hcount_reg;
    assign entry_volts   = entry_reg.volts;
    assign entry_amps    = entry_reg.amps;
    assign entry_time    = entry_reg.stamp;
    assign entry_flag    = entry_reg.flag;
    assign entry_valid   = evalid_reg;

endmodule

`default_nettype wire
